>>> src/nllrp_pkg.sv
// ----------------------------------------------------------------------------
// nllrp_pkg
// Shared types and constants for the node liveness / replica pick block.
// ----------------------------------------------------------------------------
package nllrp_pkg;

  localparam int unsigned NumNodes    = 16;
  localparam int unsigned MaxReplicas = 8;
  localparam int unsigned NodeW       = $clog2(NumNodes);
  localparam int unsigned CountW      = NodeW + 1;
  localparam int unsigned AgeW        = 8;
  localparam int unsigned LoadW       = 16;
  localparam int unsigned TimeoutW    = 8;
  localparam int unsigned WantW       = 4;
  localparam int unsigned ModeW       = 3;
  localparam int unsigned PaddrW      = 4;

  localparam logic [AgeW-1:0]  AgeMax  = '1;
  localparam logic [LoadW-1:0] LoadMax = '1;

  // request kinds
  localparam logic [ModeW-1:0] ModeTick      = 3'd0;
  localparam logic [ModeW-1:0] ModeHeartbeat = 3'd1;
  localparam logic [ModeW-1:0] ModeSelect    = 3'd2;
  localparam logic [ModeW-1:0] ModeFailover  = 3'd3;
  localparam logic [ModeW-1:0] ModeRecover   = 3'd4;

  // register word indexes
  localparam logic [1:0] RegNodeCount  = 2'd0;
  localparam logic [1:0] RegTimeout    = 2'd1;
  localparam logic [1:0] RegReplicas   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_SCAN,
    ST_PICK,
    ST_EMIT
  } state_e;

endpackage

>>> src/node_liveness_least_loaded_replica_pick.sv
// ----------------------------------------------------------------------------
// node_liveness_least_loaded_replica_pick
// Storage node liveness tracker and least-loaded replica target picker.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis group (tuser = mode, tdata = node and
//   exclude mask). Results leave on the m_axis group; tlast marks the final
//   result of a request. Registers (node count, timeout, replicas wanted) sit
//   on the APB port at 0x0, 0x4, 0x8; the user writes them only while idle (the block itself does not enforce it).
//   One shared scan walks nodes 1..N-1 one per cycle, N = effective count:
//     tick      : ages nodes 1..N-1 in the scan, then one result.
//     heartbeat, failover, recover, unused kinds : accept, then one result.
//     select    : accept, then per pick one scan of nodes 1..N-1 plus
//                 one pick state, for up to eight picks (three of fifteen
//                 storage nodes at the reset setting).
//   The scan counter sets the rate; one request is in flight at a time and
//   s_axis_tready_o is high only in the idle state.
//   The result register decouples the sides: a new request is taken while
//   the previous result still waits. When the receiver stalls, the
//   sequencer waits before loading the next result; nothing is dropped.
//   Reset: all nodes live, ages and loads zero, registers 16 / 10 / 3.
// ----------------------------------------------------------------------------
module node_liveness_least_loaded_replica_pick
  import nllrp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // request stream
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [23:0]        s_axis_tdata_i,   // [3:0] node, [19:4] exclude_mask, zero pad
  input  logic [2:0]         s_axis_tuser_i,   // [2:0] mode
  // result stream
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [7:0]         m_axis_tdata_o,   // [3:0] chosen_node, [4] status, zero pad
  output logic               m_axis_tuser_o,   // [0] granted
  output logic               m_axis_tlast_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // --- configuration registers ----------------------------------------------
  logic [CountW-1:0]   cfg_count_q;
  logic [TimeoutW-1:0] cfg_timeout_q;
  logic [WantW-1:0]    cfg_want_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q   <= CountW'(NumNodes);
      cfg_timeout_q <= TimeoutW'(10);
      cfg_want_q    <= WantW'(3);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegNodeCount: cfg_count_q   <= pwdata[CountW-1:0];
        RegTimeout:   cfg_timeout_q <= pwdata[TimeoutW-1:0];
        RegReplicas:  cfg_want_q    <= pwdata[WantW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegNodeCount: prdata = {{(32-CountW){1'b0}}, cfg_count_q};
      RegTimeout:   prdata = {{(32-TimeoutW){1'b0}}, cfg_timeout_q};
      RegReplicas:  prdata = {{(32-WantW){1'b0}}, cfg_want_q};
      default:      prdata = '0;
    endcase
  end

  // --- node state -------------------------------------------------------------
  logic [NumNodes-1:0] alive_q;
  logic [AgeW-1:0]     age_q  [NumNodes];
  logic [LoadW-1:0]    load_q [NumNodes];

  // --- request fields and sequencer state ----------------------------------
  state_e              state_q, state_d;
  logic [NumNodes-1:0] excl_q;
  logic [NumNodes-1:0] picked_q;
  logic [CountW-1:0]   cnt_q;      // effective node count, latched per request
  logic [WantW-1:0]    want_q;     // effective replicas wanted
  logic [WantW-1:0]    k_q;        // picks delivered so far
  logic [NodeW-1:0]    idx_q;      // scan pointer
  logic [NodeW-1:0]    best_q;
  logic [LoadW-1:0]    best_load_q;
  logic                found_q;
  logic                status_q;

  // --- result register ----------------------------------------------------
  logic             out_valid_q;
  logic [NodeW-1:0] out_node_q;
  logic             out_granted_q;
  logic             out_last_q;
  logic             out_status_q;

  // request decode
  logic [ModeW-1:0]    in_mode;
  logic [NodeW-1:0]    in_node;
  logic [NumNodes-1:0] in_excl;
  logic [CountW-1:0]   eff_cnt;
  logic [WantW-1:0]    eff_want;
  logic                in_range;
  logic                accept;

  assign in_mode  = s_axis_tuser_i;
  assign in_node  = s_axis_tdata_i[NodeW-1:0];
  assign in_excl  = s_axis_tdata_i[NodeW+NumNodes-1:NodeW];
  assign eff_cnt  = (cfg_count_q > CountW'(NumNodes)) ? CountW'(NumNodes) : cfg_count_q;
  assign eff_want = (cfg_want_q > WantW'(MaxReplicas)) ? WantW'(MaxReplicas) : cfg_want_q;
  assign in_range = (in_node != '0) && ({1'b0, in_node} < eff_cnt);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  // scan datapath: one node per cycle
  logic            slot_free;
  logic            scan_end;
  logic            cand_here;
  logic            better;
  logic            found_d;
  logic [AgeW-1:0] age_inc;
  logic [NumNodes-1:0] cand_mask;
  logic [NumNodes-1:0] best_bit;
  logic            pick_last;

  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign scan_end  = ({1'b0, idx_q} == (cnt_q - CountW'(1)));
  assign cand_here = alive_q[idx_q] && !excl_q[idx_q] && !picked_q[idx_q];
  assign better    = cand_here && (!found_q || (load_q[idx_q] < best_load_q));
  assign found_d   = found_q || better;
  assign age_inc   = (age_q[idx_q] < AgeMax) ? age_q[idx_q] + AgeW'(1) : age_q[idx_q];

  // candidates left besides the current pick, or the wanted count reached, decide tlast up front
  always_comb begin
    for (int n = 0; n < NumNodes; n++) begin
      cand_mask[n] = alive_q[n] && !excl_q[n] && !picked_q[n] &&
                     (n != 0) && (CountW'(n) < cnt_q);
    end
  end
  assign best_bit  = NumNodes'(1) << best_q;
  assign pick_last = ((k_q + WantW'(1)) == want_q) || !(|(cand_mask & ~best_bit));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == ModeTick && eff_cnt > CountW'(1)) begin
            state_d = ST_TICK;
          end else if (in_mode == ModeSelect && eff_cnt > CountW'(1) &&
                       eff_want != '0) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_TICK: if (scan_end) state_d = ST_EMIT;
      ST_SCAN: if (scan_end) state_d = found_d ? ST_PICK : ST_EMIT;
      ST_PICK: if (slot_free) state_d = pick_last ? ST_IDLE : ST_SCAN;
      ST_EMIT: if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      k_q      <= '0;
      found_q  <= 1'b0;
      picked_q <= '0;
      status_q <= 1'b0;
      cnt_q    <= '0;
      want_q   <= '0;
      excl_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            idx_q    <= NodeW'(1);
            k_q      <= '0;
            found_q  <= 1'b0;
            picked_q <= '0;
            cnt_q    <= eff_cnt;
            want_q   <= eff_want;
            excl_q   <= in_excl;
            status_q <= (in_mode == ModeFailover || in_mode == ModeRecover) && !in_range;
          end
        end
        ST_TICK: idx_q <= idx_q + NodeW'(1);
        ST_SCAN: begin
          idx_q   <= idx_q + NodeW'(1);
          found_q <= found_d;
        end
        ST_PICK: begin
          if (slot_free) begin
            picked_q <= picked_q | best_bit;
            k_q      <= k_q + WantW'(1);
            idx_q    <= NodeW'(1);
            found_q  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // best-so-far payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && better) begin
      best_q      <= idx_q;
      best_load_q <= load_q[idx_q];
    end
  end

  // node state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= '1;
      for (int n = 0; n < NumNodes; n++) begin
        age_q[n]  <= '0;
        load_q[n] <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && in_range) begin
            case (in_mode)
              ModeHeartbeat, ModeRecover: begin
                alive_q[in_node] <= 1'b1;
                age_q[in_node]   <= '0;
              end
              ModeFailover: alive_q[in_node] <= 1'b0;
              default: ;
            endcase
          end
        end
        ST_TICK: begin
          age_q[idx_q] <= age_inc;
          if (alive_q[idx_q] && (age_inc > cfg_timeout_q)) begin
            alive_q[idx_q] <= 1'b0;
          end
        end
        ST_PICK: begin
          if (slot_free && best_load_q < LoadMax) begin
            load_q[best_q] <= best_load_q + LoadW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_PICK || state_q == ST_EMIT) && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PICK && slot_free) begin
      out_node_q    <= best_q;
      out_granted_q <= 1'b1;
      out_last_q    <= pick_last;
      out_status_q  <= 1'b0;
    end else if (state_q == ST_EMIT && slot_free) begin
      out_node_q    <= '0;
      out_granted_q <= 1'b0;
      out_last_q    <= 1'b1;
      out_status_q  <= status_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_status_q, out_node_q};
  assign m_axis_tuser_o  = out_granted_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
